[rtl/lsrk_pkg.sv]
// ----------------------------------------------------------------------------
// lsrk_pkg
// Shared types and constants for the LIFO key store with remove by key.
// ----------------------------------------------------------------------------
package lsrk_pkg;

    // default geometry
    localparam int DEPTH_DEF    = 128;
    localparam int KEY_BITS_DEF = 64;

    // capacity register reset value
    localparam logic [7:0] CAP_RESET = 8'd128;

    // stream widths, whole bytes
    localparam int IN_W  = 80;   // 2 + 64 + 7 = 73 bits used
    localparam int OUT_W = 112;  // 2 + 32 + 8 + 64 = 106 bits used

    // command codes
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    // status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BEYOND    = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;       // capture match and select flags
        logic take_prev;  // shift down (push)
        logic take_next;  // shift up (close gap after remove)
    } cell_ctl_t;

endpackage

[rtl/lifo_store_remove_by_key_top.sv]
// ----------------------------------------------------------------------------
// lifo_store_remove_by_key_top
// Bounded LIFO key store built as a row of cells, top entry in cell 0.
// Accepting an item captures compare and select flags in every cell and enters
// S_EXEC, which shifts the row and forms the result register once the output is
// free; only then is the next item taken, so items are handled one at a time.
// Reset: fill, move total and handshake state clear, capacity becomes 128;
// stored keys are undefined until written, no clearing pass is needed.
// ----------------------------------------------------------------------------
module lifo_store_remove_by_key_top #(
    parameter int DEPTH    = lsrk_pkg::DEPTH_DEF,
    parameter int KEY_BITS = lsrk_pkg::KEY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // cmd[1:0], key[65:2], depth_index[72:66], zero pad above
    input  logic [lsrk_pkg::IN_W-1:0] s_axis_tdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // status[1:0], total_moves[33:2], fill_count[41:34], read_key[105:42]
    output logic [lsrk_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // capacity register write
    input  logic [7:0]                cfg_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CW     = (FILL_W > 8) ? FILL_W : 8;

    // input fields
    logic [1:0]          in_cmd;
    logic [63:0]         in_key_full;
    logic [6:0]          in_didx;
    logic [KEY_BITS-1:0] in_key;

    assign in_cmd      = s_axis_tdata[1:0];
    assign in_key_full = s_axis_tdata[65:2];
    assign in_didx     = s_axis_tdata[72:66];
    assign in_key      = in_key_full[KEY_BITS-1:0];

    // control and state registers
    lsrk_pkg::state_t    state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [31:0]         total_reg, total_next;
    logic [7:0]          cap_reg;
    logic                out_valid_reg, out_valid_next;

    // item registers
    logic [1:0]          cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                full_reg;
    logic                rd_ok_reg;

    // result registers
    logic [1:0]          out_status_reg;
    logic [31:0]         out_total_reg;
    logic [7:0]          out_fill_reg;
    logic [63:0]         out_rkey_reg;

    // row signals
    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [KEY_BITS-1:0] cell_rd  [DEPTH];
    logic [DEPTH-1:0]    match_vec;
    logic [DEPTH-1:0]    low_vec;
    logic [DEPTH-1:0]    shift_up_vec;
    logic [DEPTH-1:0]    occ_vec;
    logic [DEPTH-1:0]    sel_vec;
    lsrk_pkg::cell_ctl_t cell_ctl [DEPTH];

    logic                s_acc;
    logic                fire;
    logic                full_now;
    logic                rd_ok_now;
    logic [CW-1:0]       limit;
    logic [IDX_W-1:0]    hit_idx;
    logic                found;
    logic [KEY_BITS-1:0] rd_key;
    logic [32:0]         sum_wide;
    logic [1:0]          status_now;
    logic [63:0]         rkey_now;

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == lsrk_pkg::S_IDLE);
    assign cfg_ready     = 1'b1;
    assign fire          = (state_reg == lsrk_pkg::S_EXEC) &&
                           (!out_valid_reg || m_axis_tready);

    // effective capacity and decisions made at accept time
    always_comb
    begin
        if (CW'(cap_reg) > CW'(DEPTH))
        begin
            limit = CW'(DEPTH);
        end
        else
        begin
            limit = CW'(cap_reg);
        end
        full_now  = CW'(fill_reg) >= limit;
        rd_ok_now = CW'(in_didx) < CW'(fill_reg);
    end

    // first match from the top and everything below it
    assign low_vec      = match_vec & (~match_vec + 1'b1);
    assign shift_up_vec = match_vec | (~match_vec + 1'b1);
    assign found        = |match_vec;

    // one-hot to index of the first match
    always_comb
    begin
        hit_idx = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (low_vec[j])
            begin
                hit_idx = hit_idx | IDX_W'(j);
            end
        end
    end

    // gather the selected key
    always_comb
    begin
        rd_key = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            rd_key = rd_key | cell_rd[j];
        end
    end

    // cell row
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [KEY_BITS-1:0] prev_k;
        logic [KEY_BITS-1:0] next_k;

        if (g == 0)
        begin : g_first
            assign prev_k = key_reg;
        end
        else
        begin : g_mid_prev
            assign prev_k = cell_key[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_k = '0;
        end
        else
        begin : g_mid_next
            assign next_k = cell_key[g+1];
        end

        assign occ_vec[g] = CW'(g) < CW'(fill_reg);
        assign sel_vec[g] = CW'(g) == CW'(in_didx);

        assign cell_ctl[g].load      = s_acc;
        assign cell_ctl[g].take_prev = fire && (cmd_reg == lsrk_pkg::CMD_PUSH) && !full_reg;
        assign cell_ctl[g].take_next = fire && (cmd_reg == lsrk_pkg::CMD_REMOVE) &&
                                       shift_up_vec[g];

        lsrk_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk      (clk),
            .ctl      (cell_ctl[g]),
            .occupied (occ_vec[g]),
            .sel_in   (sel_vec[g]),
            .cmp_key  (in_key),
            .prev_key (prev_k),
            .next_key (next_k),
            .key_q    (cell_key[g]),
            .match_q  (match_vec[g]),
            .rd_q     (cell_rd[g])
        );
    end

    // sequencer next state and result
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        status_now     = lsrk_pkg::ST_DONE;
        rkey_now       = '0;
        sum_wide       = {1'b0, total_reg} + 33'(FILL_W'(hit_idx) + 1'b1);

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (cmd_reg)
            lsrk_pkg::CMD_PUSH:
            begin
                if (full_reg)
                begin
                    status_now = lsrk_pkg::ST_FULL;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            lsrk_pkg::CMD_REMOVE:
            begin
                if (found)
                begin
                    fill_next = fill_reg - 1'b1;
                    if (sum_wide[32])
                    begin
                        total_next = '1;
                    end
                    else
                    begin
                        total_next = sum_wide[31:0];
                    end
                end
                else
                begin
                    status_now = lsrk_pkg::ST_NOT_FOUND;
                end
            end
            lsrk_pkg::CMD_READ:
            begin
                if (rd_ok_reg)
                begin
                    rkey_now = 64'(rd_key);
                end
                else
                begin
                    status_now = lsrk_pkg::ST_BEYOND;
                end
            end
            default:
            begin
                status_now = lsrk_pkg::ST_DONE;
            end
        endcase

        case (state_reg)
            lsrk_pkg::S_IDLE:
            begin
                if (s_acc)
                begin
                    state_next = lsrk_pkg::S_EXEC;
                end
            end
            lsrk_pkg::S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = lsrk_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = lsrk_pkg::S_IDLE;
            end
        endcase

        if (!fire)
        begin
            fill_next  = fill_reg;
            total_next = total_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsrk_pkg::S_IDLE;
            fill_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            cap_reg       <= lsrk_pkg::CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cmd_reg   <= in_cmd;
            key_reg   <= in_key;
            full_reg  <= full_now;
            rd_ok_reg <= rd_ok_now;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg <= status_now;
            out_total_reg  <= total_next;
            out_fill_reg   <= 8'(fill_next);
            out_rkey_reg   <= rkey_now;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_rkey_reg, out_fill_reg, out_total_reg, out_status_reg};

endmodule

[rtl/lsrk_cell.sv]
// ----------------------------------------------------------------------------
// lsrk_cell
// One slot of the key row: holds a key, compares it against the incoming
// key, and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module lsrk_cell #(
    parameter int KEY_BITS = lsrk_pkg::KEY_BITS_DEF
) (
    input  logic                  clk,
    input  lsrk_pkg::cell_ctl_t   ctl,
    input  logic                  occupied,   // slot lies below the fill
    input  logic                  sel_in,     // slot is the read target
    input  logic [KEY_BITS-1:0]   cmp_key,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  logic [KEY_BITS-1:0]   next_key,
    output logic [KEY_BITS-1:0]   key_q,
    output logic                  match_q,
    output logic [KEY_BITS-1:0]   rd_q
);

    logic [KEY_BITS-1:0] key_reg;
    logic                match_reg;
    logic                sel_reg;

    // flags captured when an item is taken
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            match_reg <= occupied && (key_reg == cmp_key);
            sel_reg   <= sel_in;
        end
    end

    // key storage with neighbor shifts
    always_ff @(posedge clk)
    begin
        if (ctl.take_prev)
        begin
            key_reg <= prev_key;
        end
        else if (ctl.take_next)
        begin
            key_reg <= next_key;
        end
    end

    assign key_q   = key_reg;
    assign match_q = match_reg;
    assign rd_q    = sel_reg ? key_reg : '0;

endmodule

[rtl/lsrk_checker.sv]
// ----------------------------------------------------------------------------
// lsrk_checker
// Port-level checks for the LIFO key store, bound to the top level.
// ----------------------------------------------------------------------------
module lsrk_checker #(
    parameter int DEPTH = lsrk_pkg::DEPTH_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [lsrk_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // fill never exceeds the row depth
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[41:34] <= 8'(DEPTH)) || (DEPTH > 255))
        else $error("fill count beyond depth");

    // an item with an error status returns a zero key
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] != lsrk_pkg::ST_DONE)) |->
            (m_axis_tdata[105:42] == 64'd0))
        else $error("nonzero key with error status");

endmodule

bind lifo_store_remove_by_key_top lsrk_checker #(
    .DEPTH (DEPTH)
) u_lsrk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LIFO key store with remove by key. A directed
// table covers empty and full store, duplicates, every command and the
// capacity extremes, then random phases with push or remove heavy mixes run
// under changing capacity, sender gaps, receiver stalls and one long receiver
// hold. Results are checked against a behavioral model of the store or, for typed table rows, against the table.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          STORE_DEPTH = lsrk_pkg::DEPTH_DEF;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          NSTEPS      = 28;

    // one result item
    typedef struct packed {
        lsrk_pkg::status_t status;
        logic [31:0]       total;
        logic [7:0]        fill;
        logic [63:0]       rkey;
    } result_t;

    // one row of the directed table: an item or a capacity write
    typedef struct packed {
        logic        is_cfg;
        logic [7:0]  cfg_val;
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [6:0]  didx;
        logic        typed;
        result_t     want;
    } step_t;

    logic                          clk;
    logic                          rst_n;
    logic [lsrk_pkg::IN_W-1:0]     s_axis_tdata;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [lsrk_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [7:0]                    cfg_data;
    logic                          cfg_valid;
    logic                          cfg_ready;

    // model of the store
    logic [63:0]         key_store [STORE_DEPTH];
    int                  occupancy;
    logic [31:0]         move_sum;
    logic [7:0]          cap_reg;

    result_t             pending_results [$];
    int                  error_count;
    int                  cycle_count;
    int                  send_idle;
    int                  recv_stall;
    int                  hold_left;
    logic [63:0]         key_pool [8];

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    step_t plan [NSTEPS] = '{
        // empty store, then two entries, all commands
        '{1'b0, 8'd0, lsrk_pkg::CMD_READ,   64'd0, 7'd0,   1'b1,
          '{lsrk_pkg::ST_BEYOND,    32'd0, 8'd0, 64'd0}},
        '{1'b0, 8'd0, lsrk_pkg::CMD_REMOVE, 64'd5, 7'd0,   1'b1,
          '{lsrk_pkg::ST_NOT_FOUND, 32'd0, 8'd0, 64'd0}},
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   ONES,  7'd0,   1'b1,
          '{lsrk_pkg::ST_DONE,      32'd0, 8'd1, 64'd0}},
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   64'd0, 7'd0,   1'b1,
          '{lsrk_pkg::ST_DONE,      32'd0, 8'd2, 64'd0}},
        '{1'b0, 8'd0, lsrk_pkg::CMD_READ,   64'd0, 7'd0,   1'b1,
          '{lsrk_pkg::ST_DONE,      32'd0, 8'd2, 64'd0}},
        '{1'b0, 8'd0, lsrk_pkg::CMD_READ,   64'd0, 7'd1,   1'b1,
          '{lsrk_pkg::ST_DONE,      32'd0, 8'd2, ONES}},
        '{1'b0, 8'd0, lsrk_pkg::CMD_READ,   64'd0, 7'd127, 1'b1,
          '{lsrk_pkg::ST_BEYOND,    32'd0, 8'd2, 64'd0}},
        '{1'b0, 8'd0, CMD_UNUSED, 64'h8000_0000_0000_0001, 7'd127, 1'b1,
          '{lsrk_pkg::ST_DONE,      32'd0, 8'd2, 64'd0}},
        // duplicates: remove hits the topmost copy, then a deep remove
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   64'hA5A5_A5A5_5A5A_5A5A, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   64'd0, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_REMOVE, 64'd0, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_REMOVE, ONES,  7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_READ,   64'd0, 7'd0, 1'b0, '0},
        // store full at capacity two
        '{1'b1, 8'd2, lsrk_pkg::CMD_PUSH,   64'd0, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   64'h0123_4567_89AB_CDEF, 7'd0, 1'b0, '0},
        // capacity lowered below the fill
        '{1'b1, 8'd1, lsrk_pkg::CMD_PUSH,   64'd0, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   64'd7, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_REMOVE, 64'hA5A5_A5A5_5A5A_5A5A, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   64'd7, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_REMOVE, 64'd0, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   64'd1, 7'd0, 1'b0, '0},
        // zero capacity
        '{1'b1, 8'd0, lsrk_pkg::CMD_PUSH,   64'd0, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   64'd9, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_REMOVE, 64'd1, 7'd0, 1'b0, '0},
        // capacity above the store depth
        '{1'b1, 8'd255, lsrk_pkg::CMD_PUSH, 64'd0, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_PUSH,   ONES,  7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_READ,   64'd0, 7'd0, 1'b0, '0},
        '{1'b0, 8'd0, lsrk_pkg::CMD_REMOVE, 64'hFEDC_BA98_7654_3210, 7'd0, 1'b0, '0}
    };

    lifo_store_remove_by_key_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // apply one item to the store model and return its result
    function automatic result_t stack_predict(logic [1:0] cmd, logic [63:0] key,
                                              logic [6:0] didx);
        result_t r;
        int      limit;
        int      hit;
        int      d;
        r        = '0;
        r.status = lsrk_pkg::ST_DONE;
        limit    = (cap_reg > STORE_DEPTH) ? STORE_DEPTH : int'(cap_reg);
        if (cmd == lsrk_pkg::CMD_PUSH)
        begin
            if (occupancy >= limit)
                r.status = lsrk_pkg::ST_FULL;
            else
            begin
                key_store[occupancy] = key;
                occupancy++;
            end
        end
        else if (cmd == lsrk_pkg::CMD_REMOVE)
        begin
            hit = -1;
            for (int i = occupancy - 1; i >= 0 && hit < 0; i--)
                if (key_store[i] == key)
                    hit = i;
            if (hit < 0)
                r.status = lsrk_pkg::ST_NOT_FOUND;
            else
            begin
                d = occupancy - hit;
                if (move_sum > 32'hFFFF_FFFF - d)
                    move_sum = 32'hFFFF_FFFF;
                else
                    move_sum = move_sum + d;
                for (int j = hit; j + 1 < occupancy; j++)
                    key_store[j] = key_store[j + 1];
                occupancy--;
            end
        end
        else if (cmd == lsrk_pkg::CMD_READ)
        begin
            if (int'(didx) < occupancy)
                r.rkey = key_store[occupancy - 1 - didx];
            else
                r.status = lsrk_pkg::ST_BEYOND;
        end
        r.total = move_sum;
        r.fill  = occupancy[7:0];
        return r;
    endfunction

    // offer one item, wait for acceptance, then record what it should produce
    task automatic send_entry(logic [1:0] cmd, logic [63:0] key, logic [6:0] didx,
                              logic typed, result_t want);
        result_t r;
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {7'd0, didx, key, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = stack_predict(cmd, key, didx);
        pending_results.push_back(typed ? want : r);
    endtask

    // capacity write once the store has gone quiet
    task automatic write_capacity(logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cap_reg = value;
    endtask

    // key source: mostly a small pool so removes find matches
    function automatic logic [63:0] choose_key(logic for_remove);
        if (for_remove && occupancy > 0 && $urandom_range(0, 99) < 75)
            return key_store[$urandom_range(0, occupancy - 1)];
        if ($urandom_range(0, 99) < 60)
            return key_pool[$urandom_range(0, 7)];
        return {$urandom, $urandom};
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // result checker, fields shown as status/total/fill/key
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = lsrk_pkg::status_t'(m_axis_tdata[1:0]);
            got.total  = m_axis_tdata[33:2];
            got.fill   = m_axis_tdata[41:34];
            got.rkey   = m_axis_tdata[105:42];
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result item, actual %0d/%0d/%0d/%h",
                         $time, got.status, got.total, got.fill, got.rkey);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: mismatch, expected %0d/%0d/%0d/%h, actual %0d/%0d/%0d/%h",
                             $time, want.status, want.total, want.fill, want.rkey,
                             got.status, got.total, got.fill, got.rkey);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int          n_items;
        int          push_pct;
        int          remove_pct;
        int          r;
        logic [7:0]  cap;
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [6:0]  didx;

        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        cfg_data      = '0;
        cfg_valid     = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle     = 0;
        recv_stall    = 0;
        hold_left     = 0;
        occupancy     = 0;
        move_sum      = '0;
        cap_reg       = lsrk_pkg::CAP_RESET;
        for (int i = 0; i < STORE_DEPTH; i++)
            key_store[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int s = 0; s < NSTEPS; s++)
        begin
            if (plan[s].is_cfg)
                write_capacity(plan[s].cfg_val);
            else
                send_entry(plan[s].cmd, plan[s].key, plan[s].didx, plan[s].typed,
                           plan[s].want);
        end

        // random phases: capacity, command mix and idling change per phase
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    cap        = 8'd128;
                    push_pct   = 85;
                    remove_pct = 5;
                end
                1:
                begin
                    cap        = 8'd128;
                    push_pct   = 75;
                    remove_pct = 15;
                end
                2:
                begin
                    cap        = 8'd255;
                    push_pct   = 40;
                    remove_pct = 40;
                end
                3:
                begin
                    cap        = 8'd0;
                    push_pct   = 30;
                    remove_pct = 50;
                end
                4:
                begin
                    cap        = 8'($urandom_range(1, 8));
                    push_pct   = 45;
                    remove_pct = 40;
                end
                5:
                begin
                    cap        = 8'd16;
                    push_pct   = 50;
                    remove_pct = 35;
                end
                6:
                begin
                    cap        = 8'($urandom_range(0, 255));
                    push_pct   = 45;
                    remove_pct = 35;
                end
                default:
                begin
                    cap        = 8'd128;
                    push_pct   = 15;
                    remove_pct = 70;
                end
            endcase
            n_items = (ph == 3) ? 60 : 100;
            write_capacity(cap);
            case (ph % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 74;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 74;
                end
                default:
                begin
                    send_idle  = 11;
                    recv_stall = 11;
                end
            endcase
            for (int k = 0; k < 8; k++)
                key_pool[k] = {$urandom, $urandom};

            for (int i = 0; i < n_items; i++)
            begin
                // long receiver hold while items keep coming
                if (ph == 0 && i == 40)
                    hold_left = 300;
                r    = $urandom_range(0, 99);
                didx = 7'($urandom_range(0, 127));
                if (r < push_pct)
                begin
                    cmd = lsrk_pkg::CMD_PUSH;
                    key = choose_key(1'b0);
                end
                else if (r < push_pct + remove_pct)
                begin
                    cmd = lsrk_pkg::CMD_REMOVE;
                    key = choose_key(1'b1);
                end
                else if (r < 95)
                begin
                    cmd = lsrk_pkg::CMD_READ;
                    key = {$urandom, $urandom};
                    if (occupancy > 0 && $urandom_range(0, 99) < 75)
                        didx = 7'($urandom_range(0, occupancy - 1));
                end
                else
                begin
                    cmd = CMD_UNUSED;
                    key = {$urandom, $urandom};
                end
                send_entry(cmd, key, didx, 1'b0, '0);
            end
        end

        // drain and finish
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
